// ===== hw/rtl/mrr_pkg.sv =====
package mrr_pkg;

  // field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned FRAME_LEN_W = 9;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned CRC_W       = 16;

  // input commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CRC     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_LENGTH  = 2'd3;

  // frame layout
  localparam logic [FRAME_LEN_W-1:0] HDR_LEN     = 9'd3;
  localparam logic [FRAME_LEN_W-1:0] TRAILER_LEN = 9'd2;
  localparam logic [FRAME_LEN_W-1:0] COUNT_POS   = 9'd2;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_ABS_MAX = 9'd260;

  // crc-16, reflected
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 9'd260;
  localparam logic [TICK_W-1:0]      TIMEOUT_TICKS_RST = 16'd200;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [BYTE_W-1:0]      data_count;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } op_word_t;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] max_frame_len;
    logic [TICK_W-1:0]      timeout_ticks;
  } cfg_regs_t;

  typedef enum logic {
    RX_IDLE,
    RX_ACTIVE
  } rx_state_t;

  // one byte through the crc, lsb first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrr_fifo.sv =====
module mrr_fifo #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mrr_front.sv =====
module mrr_front (
  input  logic              in_valid,
  input  mrr_pkg::in_word_t in_word,
  output logic              in_stall,
  input  logic              fifo_full,
  output logic              push,
  output mrr_pkg::op_word_t push_word
);

  logic accept;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  // classify the command; the unused code is taken and dropped
  always_comb begin
    push           = 1'b0;
    push_word.op   = mrr_pkg::OP_START;
    push_word.data = in_word.rx_byte;
    unique case (in_word.command)
      mrr_pkg::CMD_START: begin
        push         = accept;
        push_word.op = mrr_pkg::OP_START;
      end
      mrr_pkg::CMD_BYTE: begin
        push         = accept;
        push_word.op = mrr_pkg::OP_BYTE;
      end
      mrr_pkg::CMD_TICK: begin
        push         = accept;
        push_word.op = mrr_pkg::OP_TICK;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mrr_back.sv =====
module mrr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mrr_pkg::cfg_regs_t cfg,
  input  logic               fifo_empty,
  input  mrr_pkg::op_word_t  pop_word,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mrr_pkg::out_word_t out_word
);

  localparam int unsigned LW = mrr_pkg::FRAME_LEN_W;
  localparam int unsigned BW = mrr_pkg::BYTE_W;
  localparam int unsigned TW = mrr_pkg::TICK_W;
  localparam int unsigned CW = mrr_pkg::CRC_W;

  mrr_pkg::rx_state_t state_r, state_nxt;

  logic [LW-1:0] byte_index_r, byte_index_nxt;
  logic [LW-1:0] expected_len_r, expected_len_nxt;
  logic [BW-1:0] data_count_r, data_count_nxt;
  logic [CW-1:0] crc_r, crc_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;

  logic               out_valid_r, out_valid_nxt;
  mrr_pkg::out_word_t out_word_r;
  mrr_pkg::out_word_t res_word;
  logic               emit;

  logic          active;
  logic [LW-1:0] crc_pos;
  logic [LW-1:0] new_len;
  logic [TW-1:0] tick_inc;
  logic [CW-1:0] crc_upd;

  assign active    = (state_r == mrr_pkg::RX_ACTIVE);
  assign pop       = !fifo_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign crc_pos  = expected_len_r - mrr_pkg::TRAILER_LEN;
  assign new_len  = {1'b0, pop_word.data} + mrr_pkg::HDR_LEN + mrr_pkg::TRAILER_LEN;
  assign tick_inc = elapsed_r + TW'(1);
  assign crc_upd  = mrr_pkg::crc16_byte(crc_r, pop_word.data);

  // next state
  always_comb begin
    state_nxt = state_r;
    if (pop) begin
      unique case (pop_word.op)
        mrr_pkg::OP_START: state_nxt = mrr_pkg::RX_ACTIVE;
        mrr_pkg::OP_BYTE,
        mrr_pkg::OP_TICK: begin
          if (emit) begin
            state_nxt = mrr_pkg::RX_IDLE;
          end
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  // frame datapath and result
  always_comb begin
    byte_index_nxt         = byte_index_r;
    expected_len_nxt       = expected_len_r;
    data_count_nxt         = data_count_r;
    crc_nxt                = crc_r;
    mismatch_nxt           = mismatch_r;
    elapsed_nxt            = elapsed_r;
    emit                   = 1'b0;
    res_word.status        = mrr_pkg::STATUS_OK;
    res_word.frame_length  = byte_index_r;
    res_word.data_count    = data_count_r;
    if (pop) begin
      unique case (pop_word.op)
        mrr_pkg::OP_START: begin
          byte_index_nxt   = '0;
          expected_len_nxt = mrr_pkg::HDR_LEN;
          data_count_nxt   = '0;
          crc_nxt          = mrr_pkg::CRC_INIT;
          mismatch_nxt     = 1'b0;
          elapsed_nxt      = '0;
        end
        mrr_pkg::OP_TICK: begin
          if (active) begin
            elapsed_nxt = tick_inc;
            if (tick_inc >= cfg.timeout_ticks) begin
              emit            = 1'b1;
              res_word.status = mrr_pkg::STATUS_TIMEOUT;
            end
          end
        end
        mrr_pkg::OP_BYTE: begin
          if (active) begin
            if (byte_index_r < mrr_pkg::HDR_LEN || byte_index_r < crc_pos) begin
              // header or data byte
              crc_nxt = crc_upd;
              if (byte_index_r == mrr_pkg::COUNT_POS) begin
                data_count_nxt   = pop_word.data;
                expected_len_nxt = new_len;
                byte_index_nxt   = mrr_pkg::HDR_LEN;
                if (new_len > cfg.max_frame_len) begin
                  emit                  = 1'b1;
                  res_word.status       = mrr_pkg::STATUS_LENGTH;
                  res_word.frame_length = mrr_pkg::HDR_LEN;
                  res_word.data_count   = pop_word.data;
                end
              end else begin
                byte_index_nxt = byte_index_r + LW'(1);
              end
            end else if (byte_index_r == crc_pos) begin
              // crc low byte
              mismatch_nxt   = mismatch_r || (pop_word.data != crc_r[BW-1:0]);
              byte_index_nxt = byte_index_r + LW'(1);
            end else begin
              // crc high byte ends the frame
              mismatch_nxt          = mismatch_r || (pop_word.data != crc_r[CW-1:BW]);
              byte_index_nxt        = byte_index_r + LW'(1);
              emit                  = 1'b1;
              res_word.frame_length = byte_index_r + LW'(1);
              res_word.status       = mismatch_nxt ? mrr_pkg::STATUS_CRC
                                                   : mrr_pkg::STATUS_OK;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mrr_pkg::RX_IDLE;
      byte_index_r   <= '0;
      expected_len_r <= mrr_pkg::HDR_LEN;
      data_count_r   <= '0;
      crc_r          <= mrr_pkg::CRC_INIT;
      mismatch_r     <= 1'b0;
      elapsed_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      byte_index_r   <= byte_index_nxt;
      expected_len_r <= expected_len_nxt;
      data_count_r   <= data_count_nxt;
      crc_r          <= crc_nxt;
      mismatch_r     <= mismatch_nxt;
      elapsed_r      <= elapsed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_word_r <= res_word;
    end
  end

endmodule

// ===== hw/rtl/modbus_rtu_response_receiver_unit.sv =====
// channel  | ports                              | direction
// ---------+------------------------------------+----------
// in       | in_valid, in_stall, in_word        | command and byte words in
// out      | out_valid, out_stall, out_word     | status words out
// cfg      | cfg_valid, cfg_ready, cfg_index,   | register writes in
//          | cfg_wdata                          |
//
// one word per cycle sustained while in_stall is low; a taken word goes into the front queue,
// and is read from it while the output register is empty or being taken; there the crc step,
// length check and tick compare finish, and the result is registered into the output register.
// rst_n is synchronous; it clears the queue, the frame state and the output valid.
// in_stall rises only while the queue is full; the back stage drains the queue
// while the output register is empty or being taken.
module modbus_rtu_response_receiver_unit #(
  parameter int unsigned FIFO_DEPTH = mrr_pkg::FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mrr_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mrr_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned OP_W = $bits(mrr_pkg::op_word_t);

  mrr_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic               fifo_full, fifo_empty, push, pop;
  mrr_pkg::op_word_t  push_word, pop_word;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrr_pkg::CFG_MAX_FRAME_LEN:
          cfg_nxt.max_frame_len = cfg_wdata[mrr_pkg::FRAME_LEN_W-1:0];
        mrr_pkg::CFG_TIMEOUT_TICKS:
          cfg_nxt.timeout_ticks = cfg_wdata[mrr_pkg::TICK_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len <= mrr_pkg::MAX_FRAME_LEN_RST;
      cfg_r.timeout_ticks <= mrr_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrr_front u_front (
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .fifo_full (fifo_full),
    .push      (push),
    .push_word (push_word)
  );

  mrr_fifo #(
    .WIDTH (OP_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .pop       (pop),
    .pop_data  (pop_word),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  mrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .pop_word   (pop_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  // a finished good frame is exactly header, data and crc long
  a_ok_length : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == mrr_pkg::STATUS_OK) |->
    (out_word.frame_length == {1'b0, out_word.data_count} + mrr_pkg::HDR_LEN
                              + mrr_pkg::TRAILER_LEN))
    else $error("ok result with wrong frame length");

  // a length error is always reported at the count byte
  a_len_err_at_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == mrr_pkg::STATUS_LENGTH) |->
    (out_word.frame_length == mrr_pkg::HDR_LEN))
    else $error("length error away from the count byte");

  // no result ever reports more bytes than the longest frame
  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.frame_length <= mrr_pkg::FRAME_LEN_ABS_MAX))
    else $error("frame length beyond the longest frame");

  // nothing is queued while the queue reports full
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (push |-> !fifo_full))
    else $error("queue written while full");

endmodule
